// ===== design/cfvs_pkg.sv =====
// Package for the collision/frequency victim selector.
// Holds the fixed stream field widths and packing offsets; no dependencies.
`default_nettype none

package cfvs_pkg;

  // Input item fields (tdata, lowest bit first)
  localparam int unsigned SetIdxW  = 6;
  localparam int unsigned WayIdxW  = 3;
  localparam int unsigned FreqValW = 16;
  localparam int unsigned SetLsb   = 0;
  localparam int unsigned WayLsb   = SetLsb + SetIdxW;
  localparam int unsigned FreqLsb  = WayLsb + WayIdxW;
  localparam int unsigned InDataW  = 32;

  // Result item fields
  localparam int unsigned VictimW  = 3;
  localparam int unsigned OutDataW = 8;

  // Request kinds carried on the input tuser bit
  typedef enum logic {
    REQ_VICTIM     = 1'b0,
    REQ_FREQ_WRITE = 1'b1
  } req_type_e;

endpackage

`default_nettype wire

// ===== design/collision_frequency_victim_select_core.sv =====
// Collision/frequency victim selector: top level with count memories and scan sequencer.
// Depends on cfvs_pkg.
`default_nettype none

// After reset the block sweeps both count memories to zero, one entry per cycle,
// with s_axis_tready_o low for the whole sweep. A frequency write (tuser = 1)
// gives no result. For a victim request (tuser = 0), one shared subtract/compare
// unit walks the ways of the set one per cycle through the single read port of
// each memory, and the same pass writes back each collision count plus one
// (saturating). The result (victim way in tdata, any_positive in tuser) sits in
// an output register; the next item is taken while it waits, and a second
// victim result holds until the first has been transferred. A request for a
// set at or beyond NUM_SETS returns way 0 with any_positive low and changes
// nothing.
module collision_frequency_victim_select_core
  import cfvs_pkg::*;
#(
  parameter int unsigned NUM_SETS    = 64,
  parameter int unsigned WAYS        = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,  // set_index[5:0], way_index[8:6],
                                                    // freq_value[24:9], zero pad
  input  wire logic                s_axis_tuser_i,  // req_type
  // Result stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,  // victim_way[2:0], zero pad
  output logic                     m_axis_tuser_o   // any_positive
);

  localparam int unsigned Depth = NUM_SETS * WAYS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SetW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WCntW = WayW + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Count memories
  logic [COUNT_WIDTH-1:0] coll_mem [Depth];
  logic [COUNT_WIDTH-1:0] freq_mem [Depth];

  // Control registers
  state_e                 state_q, state_d;
  logic [AddrW-1:0]       clr_q, clr_d;
  logic [AddrW-1:0]       base_q, base_d;
  logic [WCntW-1:0]       rd_way_q, rd_way_d;
  logic                   pv_q, pv_d;
  logic [WayW-1:0]        pw_q, pw_d;
  logic [AddrW-1:0]       wr_addr_q, wr_addr_d;
  logic [COUNT_WIDTH-1:0] best_q, best_d;
  logic [WayW-1:0]        pick_q, pick_d;
  logic                   found_q, found_d;
  logic                   out_vld_q, out_vld_d;
  logic [VictimW-1:0]     out_way_q, out_way_d;
  logic                   out_pos_q, out_pos_d;

  // Memory read data
  logic [COUNT_WIDTH-1:0] coll_rd_q;
  logic [COUNT_WIDTH-1:0] freq_rd_q;

  // Decoded input fields
  logic [31:0]            set_ext, way_ext, fv_ext, pick_ext;
  logic [SetW-1:0]        set_trunc;
  logic [WayW-1:0]        way_trunc;
  logic                   set_ok, way_ok;
  logic                   in_xfer;

  // Memory port controls
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic                   coll_we, freq_we;
  logic [AddrW-1:0]       coll_waddr, freq_waddr;
  logic [COUNT_WIDTH-1:0] coll_wdata, freq_wdata;

  // Shared compare unit
  logic                   gt;
  logic [COUNT_WIDTH-1:0] diff;
  logic                   take;
  logic [COUNT_WIDTH-1:0] coll_inc;

  // Unpack input fields
  assign set_ext   = 32'(s_axis_tdata_i[SetLsb +: SetIdxW]);
  assign way_ext   = 32'(s_axis_tdata_i[WayLsb +: WayIdxW]);
  assign fv_ext    = 32'(s_axis_tdata_i[FreqLsb +: FreqValW]);
  assign set_trunc = set_ext[SetW-1:0];
  assign way_trunc = way_ext[WayW-1:0];
  assign set_ok    = (set_ext < NUM_SETS);
  assign way_ok    = (way_ext < WAYS);
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Compare one way: positive difference that beats the best so far
  assign gt       = (coll_rd_q > freq_rd_q);
  assign diff     = coll_rd_q - freq_rd_q;
  assign take     = pv_q && gt && (diff > best_q);
  assign coll_inc = (coll_rd_q == {COUNT_WIDTH{1'b1}}) ? coll_rd_q
                                                       : coll_rd_q + 1'b1;

  // Read address of the way being issued
  assign rd_addr = base_q + AddrW'(rd_way_q);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    base_d     = base_q;
    rd_way_d   = rd_way_q;
    pv_d       = 1'b0;
    pw_d       = pw_q;
    wr_addr_d  = wr_addr_q;
    best_d     = best_q;
    pick_d     = pick_q;
    found_d    = found_q;
    out_vld_d  = out_vld_q;
    out_way_d  = out_way_q;
    out_pos_d  = out_pos_q;
    rd_en      = 1'b0;
    coll_we    = 1'b0;
    freq_we    = 1'b0;
    coll_waddr = wr_addr_q;
    freq_waddr = AddrW'(set_trunc * WAYS) + AddrW'(way_trunc);
    coll_wdata = coll_inc;
    freq_wdata = fv_ext[COUNT_WIDTH-1:0];

    // Drop the result once transferred
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        coll_we    = 1'b1;
        freq_we    = 1'b1;
        coll_waddr = clr_q;
        freq_waddr = clr_q;
        coll_wdata = '0;
        freq_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser_i == REQ_FREQ_WRITE) begin
            freq_we = set_ok && way_ok;
          end else begin
            base_d   = AddrW'(set_trunc * WAYS);
            rd_way_d = '0;
            best_d   = '0;
            pick_d   = '0;
            found_d  = 1'b0;
            state_d  = set_ok ? ST_SCAN : ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next read
        if (rd_way_q < WCntW'(WAYS)) begin
          rd_en     = 1'b1;
          rd_way_d  = rd_way_q + 1'b1;
          pv_d      = 1'b1;
          pw_d      = rd_way_q[WayW-1:0];
          wr_addr_d = rd_addr;
        end
        // Compare and write back the way read last cycle
        if (pv_q) begin
          coll_we = 1'b1;
          if (take) begin
            best_d  = diff;
            pick_d  = pw_q;
            found_d = 1'b1;
          end
          if (pw_q == WayW'(WAYS - 1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_way_d = pick_ext[VictimW-1:0];
          out_pos_d = found_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign pick_ext = 32'(pick_q);

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      base_q    <= '0;
      rd_way_q  <= '0;
      pv_q      <= 1'b0;
      pw_q      <= '0;
      wr_addr_q <= '0;
      best_q    <= '0;
      pick_q    <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      out_way_q <= '0;
      out_pos_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      base_q    <= base_d;
      rd_way_q  <= rd_way_d;
      pv_q      <= pv_d;
      pw_q      <= pw_d;
      wr_addr_q <= wr_addr_d;
      best_q    <= best_d;
      pick_q    <= pick_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      out_way_q <= out_way_d;
      out_pos_q <= out_pos_d;
    end
  end

  // Collision count memory
  always_ff @(posedge clk_i) begin
    if (coll_we) begin
      coll_mem[coll_waddr] <= coll_wdata;
    end
    if (rd_en) begin
      coll_rd_q <= coll_mem[rd_addr];
    end
  end

  // Frequency count memory
  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[freq_waddr] <= freq_wdata;
    end
    if (rd_en) begin
      freq_rd_q <= freq_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutDataW'(out_way_q);
  assign m_axis_tuser_o  = out_pos_q;

endmodule

`default_nettype wire

// ===== design/cfvs_checker.sv =====
// Port-level checks for the collision/frequency victim selector, and the bind
// that attaches them to the top level. Depends on cfvs_pkg.
`default_nettype none

module cfvs_checker
  import cfvs_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic [InDataW-1:0]  s_axis_tdata_i,
  input wire logic                s_axis_tuser_i,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o,
  input wire logic                m_axis_tuser_o
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // A defaulted result always names way 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("no positive way but victim is not way 0");

  // A victim request keeps the input closed for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_VICTIM) |=>
      !s_axis_tready_o)
    else $error("input ready right after a victim request");

  // Pad bits above the victim way stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDataW-1:VictimW] == '0)
    else $error("result pad bits not zero");

endmodule

bind collision_frequency_victim_select_core cfvs_checker u_cfvs_checker (.*);

`default_nettype wire
